### design/assert_macros.svh
// assertion macros shared by the cluster finder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SPCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spcf assertion failed");

// condition that must never be seen
`define SPCF_ASSERT_NEVER(lbl, expr) \
  `SPCF_ASSERT(lbl, !(expr))

`endif

### design/spcf_pkg.sv
// shared types and constants of the strip peak cluster finder
// no dependencies
`timescale 1ns / 1ps

package spcf_pkg;

  localparam int MaxHits = 64;
  localparam int AddrW   = $clog2(MaxHits);
  localparam int CntW    = AddrW + 1;

  typedef struct packed {
    logic [2:0]         row;
    logic [7:0]         strip;
    logic [9:0]         adc;
    logic signed [14:0] center;
  } hit_t;

  typedef enum logic [1:0] {
    CfgWinLo = 2'd0,
    CfgWinHi = 2'd1,
    CfgThr   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RdPrev  = 3'd0,
    RdScan  = 3'd1,
    RdRight = 3'd2,
    RdLeft  = 3'd3,
    RdSrc   = 3'd4
  } rd_sel_e;

  typedef struct packed {
    logic    latch_in;
    logic    ins_init;
    rd_sel_e rd_sel;
    logic    wr_shift;
    logic    wr_hit;
    logic    pk_init;
    logic    pk_step;
    logic    cl_start;
    logic    take_right;
    logic    take_left;
    logic    prev_peak;
    logic    ac_sq;
    logic    ac_mul;
    logic    ac_add;
    logic    zero_mom;
    logic    cen_start;
    logic    cen_fix;
    logic    rad1;
    logic    rad2;
    logic    rad3;
    logic    rad4;
    logic    sq_step;
    logic    sig_start;
    logic    dv_step;
    logic    sig_fix;
    logic    rm_init;
    logic    rm_wr;
    logic    rm_end;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic hit_ok;
    logic last;
    logic pos_zero;
    logic key_gt;
    logic cnt_zero;
    logic scan_last;
    logic right_more;
    logic left_more;
    logic joins;
    logic m0_zero;
    logic dv_done;
    logic sq_done;
    logic src_more;
  } sts_t;

endpackage

### design/spcf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module spcf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/spcf_dp.sv
// datapath: hit store, sorted insert, moments, divider and square root units
// depends on spcf_pkg, spcf_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spcf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          row_i,
  input  logic [7:0]          strip_i,
  input  logic [9:0]          adc_i,
  input  logic signed [12:0]  time_bin_i,
  input  logic signed [14:0]  strip_center_i,
  input  logic                last_hit_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i,
  input  spcf_pkg::cmd_t      cmd_i,
  output spcf_pkg::sts_t      sts_o,
  output logic                cluster_valid_o,
  output logic [2:0]          cluster_row_o,
  output logic [7:0]          peak_strip_o,
  output logic signed [14:0]  peak_center_o,
  output logic [6:0]          strip_count_o,
  output logic [15:0]         sum_adc_o,
  output logic signed [14:0]  centroid_o,
  output logic [14:0]         sigma_o,
  output logic                last_cluster_o
);

  import spcf_pkg::*;

  logic signed [12:0] win_lo_q, win_hi_q;
  logic [9:0]         thr_q;
  hit_t               hit_q;
  logic signed [12:0] tb_q;
  logic               last_q;
  logic [CntW-1:0]    cnt_q, pos_q, idx_q, left_q, right_q, src_q, dst_q;
  hit_t               peak_q, prev_q, mem_q;
  logic [AddrW-1:0]   peak_idx_q;
  logic [28:0]        x2_q;
  logic signed [25:0] p1_q;
  logic [38:0]        p2_q;
  logic [15:0]        m0_q;
  logic signed [31:0] m1_q;
  logic [44:0]        m2_q;
  logic [47:0]        pp_lo_q;
  logic [28:0]        pp_hi_q;
  logic [61:0]        sq_q;
  logic [60:0]        prod_q;
  logic [60:0]        sn_q, sres_q, sbit_q;
  logic [32:0]        dv_q_q;
  logic [16:0]        dv_r_q, dv_d_q;
  logic [5:0]         dv_cnt_q;
  logic               dv_neg_q;
  logic signed [14:0] cen_q;
  logic [14:0]        sig_q;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [CntW-1:0]      raddr_full;
  hit_t                 ram_wdata, rd_hit;
  logic [$bits(hit_t)-1:0] ram_rdata;

  logic signed [29:0] sqr;
  logic signed [25:0] p1;
  logic [38:0]        p2;
  logic signed [32:0] num;
  logic [32:0]        num_mag;
  logic [31:0]        m1n;
  logic [17:0]        dv_t, dv_tr;
  logic               dv_ge;
  logic [32:0]        q_adj, cen_v;
  logic [61:0]        rad_diff;
  logic [60:0]        sq_sum;
  logic [CntW-1:0]    csize;

  // ram address and data selection
  always_comb begin
    case (cmd_i.rd_sel)
      RdPrev:  raddr_full = pos_q - CntW'(1);
      RdScan:  raddr_full = idx_q;
      RdRight: raddr_full = right_q + CntW'(1);
      RdLeft:  raddr_full = left_q - CntW'(1);
      RdSrc:   raddr_full = src_q;
      default: raddr_full = idx_q;
    endcase
  end

  assign ram_raddr = raddr_full[AddrW-1:0];
  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_hit | cmd_i.rm_wr;
  assign ram_waddr = cmd_i.rm_wr ? dst_q[AddrW-1:0] : pos_q[AddrW-1:0];
  assign ram_wdata = cmd_i.wr_hit ? hit_q : rd_hit;
  assign rd_hit    = ram_rdata;

  spcf_ram #(
    .Width ($bits(hit_t)),
    .Depth (MaxHits)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // status
  assign sts_o.hit_ok = (tb_q >= win_lo_q) && (tb_q <= win_hi_q) &&
                        (cnt_q < CntW'(MaxHits));
  assign sts_o.last      = last_q;
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.key_gt    = {rd_hit.row, rd_hit.strip} > {hit_q.row, hit_q.strip};
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.scan_last = ((idx_q + CntW'(1)) == cnt_q);
  assign sts_o.right_more = ((right_q + CntW'(1)) < cnt_q);
  assign sts_o.left_more = (left_q != '0);
  assign sts_o.joins = (rd_hit.adc <= prev_q.adc) && (rd_hit.adc >= thr_q) &&
                       (rd_hit.row == prev_q.row) &&
                       ((rd_hit.strip == prev_q.strip) ||
                        ({1'b0, rd_hit.strip} == {1'b0, prev_q.strip} + 9'd1) ||
                        ({1'b0, prev_q.strip} == {1'b0, rd_hit.strip} + 9'd1));
  assign sts_o.m0_zero  = (m0_q == '0);
  assign sts_o.dv_done  = (dv_cnt_q == '0);
  assign sts_o.sq_done  = (sbit_q == '0);
  assign sts_o.src_more = (src_q < cnt_q);

  // arithmetic
  assign sqr      = mem_q.center * mem_q.center;
  assign p1       = $signed({1'b0, mem_q.adc}) * mem_q.center;
  assign p2       = 39'(mem_q.adc) * 39'(x2_q);
  assign num      = $signed({m1_q, 1'b0}) + $signed({17'd0, m0_q});
  assign num_mag  = num[32] ? 33'(-num) : 33'(num);
  assign m1n      = m1_q[31] ? 32'(-m1_q) : 32'(m1_q);
  assign dv_t     = {dv_r_q, dv_q_q[32]};
  assign dv_ge    = (dv_t >= {1'b0, dv_d_q});
  assign dv_tr    = dv_t - {1'b0, dv_d_q};
  assign q_adj    = dv_q_q + 33'(dv_r_q != '0);
  assign cen_v    = dv_neg_q ? (33'd0 - q_adj) : dv_q_q;
  assign rad_diff = {1'b0, prod_q} - sq_q;
  assign sq_sum   = sres_q + sbit_q;
  assign csize    = right_q - left_q + CntW'(1);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q        <= -13'sd50;
      win_hi_q        <= 13'sd50;
      thr_q           <= '0;
      cnt_q           <= '0;
      cluster_valid_o <= 1'b0;
    end else begin
      cluster_valid_o <= cmd_i.emit;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgWinLo: win_lo_q <= cfg_data_i;
          CfgWinHi: win_hi_q <= cfg_data_i;
          CfgThr:   thr_q    <= cfg_data_i[9:0];
          default:  ;
        endcase
      end
      if (cmd_i.wr_hit) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.rm_end) begin
        cnt_q <= cnt_q - csize;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      hit_q  <= '{row: row_i, strip: strip_i, adc: adc_i, center: strip_center_i};
      tb_q   <= time_bin_i;
      last_q <= last_hit_i;
    end
    if (cmd_i.ins_init) pos_q <= cnt_q;
    if (cmd_i.wr_shift) pos_q <= pos_q - CntW'(1);
    if (cmd_i.pk_init) idx_q <= '0;
    if (cmd_i.pk_step) begin
      if (idx_q == '0 || rd_hit.adc > peak_q.adc) begin
        peak_q     <= rd_hit;
        peak_idx_q <= idx_q[AddrW-1:0];
      end
      idx_q <= idx_q + CntW'(1);
    end
    if (cmd_i.cl_start) begin
      left_q  <= {1'b0, peak_idx_q};
      right_q <= {1'b0, peak_idx_q};
      prev_q  <= peak_q;
      mem_q   <= peak_q;
      m0_q    <= '0;
      m1_q    <= '0;
      m2_q    <= '0;
    end
    if (cmd_i.take_right) begin
      right_q <= right_q + CntW'(1);
      prev_q  <= rd_hit;
      mem_q   <= rd_hit;
    end
    if (cmd_i.take_left) begin
      left_q <= left_q - CntW'(1);
      prev_q <= rd_hit;
      mem_q  <= rd_hit;
    end
    if (cmd_i.prev_peak) prev_q <= peak_q;
    if (cmd_i.ac_sq) x2_q <= sqr[28:0];
    if (cmd_i.ac_mul) begin
      p1_q <= p1;
      p2_q <= p2;
    end
    if (cmd_i.ac_add) begin
      m0_q <= m0_q + 16'(mem_q.adc);
      m1_q <= m1_q + 32'(p1_q);
      m2_q <= m2_q + 45'(p2_q);
    end
    if (cmd_i.zero_mom) begin
      cen_q <= peak_q.center;
      sig_q <= '0;
    end
    if (cmd_i.cen_start) begin
      dv_q_q   <= num_mag;
      dv_r_q   <= '0;
      dv_d_q   <= {m0_q, 1'b0};
      dv_cnt_q <= 6'd33;
      dv_neg_q <= num[32];
    end
    if (cmd_i.sig_start) begin
      dv_q_q   <= 33'(sres_q[30:0]);
      dv_r_q   <= '0;
      dv_d_q   <= 17'(m0_q);
      dv_cnt_q <= 6'd33;
      dv_neg_q <= 1'b0;
    end
    if (cmd_i.dv_step) begin
      dv_r_q   <= dv_ge ? dv_tr[16:0] : dv_t[16:0];
      dv_q_q   <= {dv_q_q[31:0], dv_ge};
      dv_cnt_q <= dv_cnt_q - 6'd1;
    end
    if (cmd_i.cen_fix) cen_q <= cen_v[14:0];
    if (cmd_i.rad1) begin
      pp_lo_q <= 48'(m0_q) * 48'(m2_q[31:0]);
      sq_q    <= 62'(m1n[30:0]) * 62'(m1n[30:0]);
    end
    if (cmd_i.rad2) pp_hi_q <= 29'(m0_q) * 29'(m2_q[44:32]);
    if (cmd_i.rad3) prod_q <= {pp_hi_q, 32'd0} + 61'(pp_lo_q);
    if (cmd_i.rad4) begin
      // negative radicand clamps to zero
      sn_q   <= rad_diff[61] ? '0 : rad_diff[60:0];
      sres_q <= '0;
      sbit_q <= 61'(1) << 60;
    end
    if (cmd_i.sq_step) begin
      if (sn_q >= sq_sum) begin
        sn_q   <= sn_q - sq_sum;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.sig_fix) sig_q <= dv_q_q[14:0];
    if (cmd_i.rm_init) begin
      src_q <= right_q + CntW'(1);
      dst_q <= left_q;
    end
    if (cmd_i.rm_wr) begin
      src_q <= src_q + CntW'(1);
      dst_q <= dst_q + CntW'(1);
    end
    if (cmd_i.emit) begin
      cluster_row_o  <= peak_q.row;
      peak_strip_o   <= peak_q.strip;
      peak_center_o  <= peak_q.center;
      strip_count_o  <= 7'(csize);
      sum_adc_o      <= m0_q;
      centroid_o     <= cen_q;
      sigma_o        <= sig_q;
      last_cluster_o <= (cnt_q == '0);
    end
  end

  `SPCF_ASSERT(a_cnt_bound, cnt_q <= CntW'(MaxHits))
  `SPCF_ASSERT(a_valid_pulse, cluster_valid_o |=> !cluster_valid_o)
  `SPCF_ASSERT(a_cnt_inc, cmd_i.wr_hit |=> (cnt_q == $past(cnt_q) + CntW'(1)))

endmodule

### design/spcf_ctrl.sv
// controller: sequences insertion, peak search, growth, moments and removal
// depends on spcf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spcf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  spcf_pkg::sts_t sts_i,
  output spcf_pkg::cmd_t cmd_o,
  output logic           busy_o
);

  import spcf_pkg::*;

  typedef enum logic [30:0] {
    StIdle     = 31'd1 << 0,
    StInsChk   = 31'd1 << 1,
    StInsRd    = 31'd1 << 2,
    StInsCmp   = 31'd1 << 3,
    StPkInit   = 31'd1 << 4,
    StPkRd     = 31'd1 << 5,
    StPkCmp    = 31'd1 << 6,
    StClStart  = 31'd1 << 7,
    StAcSq     = 31'd1 << 8,
    StAcMul    = 31'd1 << 9,
    StAcAdd    = 31'd1 << 10,
    StGrR      = 31'd1 << 11,
    StGrRc     = 31'd1 << 12,
    StGrL      = 31'd1 << 13,
    StGrLc     = 31'd1 << 14,
    StMom      = 31'd1 << 15,
    StDvCen    = 31'd1 << 16,
    StCenFix   = 31'd1 << 17,
    StRad1     = 31'd1 << 18,
    StRad2     = 31'd1 << 19,
    StRad3     = 31'd1 << 20,
    StRad4     = 31'd1 << 21,
    StSq       = 31'd1 << 22,
    StSigStart = 31'd1 << 23,
    StDvSig    = 31'd1 << 24,
    StSigFix   = 31'd1 << 25,
    StRmInit   = 31'd1 << 26,
    StRmRd     = 31'd1 << 27,
    StRmWr     = 31'd1 << 28,
    StRmEnd    = 31'd1 << 29,
    StEmit     = 31'd1 << 30
  } state_e;

  state_e state_q, state_d;
  logic   dir_q, dir_d;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d     = state_q;
    dir_d       = dir_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RdScan;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = StInsChk;
        end
      end
      StInsChk: begin
        if (sts_i.hit_ok) begin
          cmd_o.ins_init = 1'b1;
          state_d = StInsRd;
        end else begin
          state_d = sts_i.last ? StPkInit : StIdle;
        end
      end
      StInsRd: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_hit = 1'b1;
          state_d = sts_i.last ? StPkInit : StIdle;
        end else begin
          cmd_o.rd_sel = RdPrev;
          state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        if (sts_i.key_gt) begin
          cmd_o.wr_shift = 1'b1;
          state_d = StInsRd;
        end else begin
          cmd_o.wr_hit = 1'b1;
          state_d = sts_i.last ? StPkInit : StIdle;
        end
      end
      StPkInit: begin
        if (sts_i.cnt_zero) begin
          state_d = StIdle;
        end else begin
          cmd_o.pk_init = 1'b1;
          state_d = StPkRd;
        end
      end
      StPkRd: begin
        cmd_o.rd_sel = RdScan;
        state_d = StPkCmp;
      end
      StPkCmp: begin
        cmd_o.pk_step = 1'b1;
        state_d = sts_i.scan_last ? StClStart : StPkRd;
      end
      StClStart: begin
        cmd_o.cl_start = 1'b1;
        dir_d = 1'b1;
        state_d = StAcSq;
      end
      StAcSq: begin
        cmd_o.ac_sq = 1'b1;
        state_d = StAcMul;
      end
      StAcMul: begin
        cmd_o.ac_mul = 1'b1;
        state_d = StAcAdd;
      end
      StAcAdd: begin
        cmd_o.ac_add = 1'b1;
        state_d = dir_q ? StGrR : StGrL;
      end
      StGrR: begin
        if (sts_i.right_more) begin
          cmd_o.rd_sel = RdRight;
          state_d = StGrRc;
        end else begin
          cmd_o.prev_peak = 1'b1;
          dir_d = 1'b0;
          state_d = StGrL;
        end
      end
      StGrRc: begin
        if (sts_i.joins) begin
          cmd_o.take_right = 1'b1;
          state_d = StAcSq;
        end else begin
          cmd_o.prev_peak = 1'b1;
          dir_d = 1'b0;
          state_d = StGrL;
        end
      end
      StGrL: begin
        if (sts_i.left_more) begin
          cmd_o.rd_sel = RdLeft;
          state_d = StGrLc;
        end else begin
          state_d = StMom;
        end
      end
      StGrLc: begin
        if (sts_i.joins) begin
          cmd_o.take_left = 1'b1;
          state_d = StAcSq;
        end else begin
          state_d = StMom;
        end
      end
      StMom: begin
        if (sts_i.m0_zero) begin
          cmd_o.zero_mom = 1'b1;
          state_d = StRmInit;
        end else begin
          cmd_o.cen_start = 1'b1;
          state_d = StDvCen;
        end
      end
      StDvCen: begin
        if (sts_i.dv_done) begin
          state_d = StCenFix;
        end else begin
          cmd_o.dv_step = 1'b1;
        end
      end
      StCenFix: begin
        cmd_o.cen_fix = 1'b1;
        state_d = StRad1;
      end
      StRad1: begin
        cmd_o.rad1 = 1'b1;
        state_d = StRad2;
      end
      StRad2: begin
        cmd_o.rad2 = 1'b1;
        state_d = StRad3;
      end
      StRad3: begin
        cmd_o.rad3 = 1'b1;
        state_d = StRad4;
      end
      StRad4: begin
        cmd_o.rad4 = 1'b1;
        state_d = StSq;
      end
      StSq: begin
        if (sts_i.sq_done) begin
          state_d = StSigStart;
        end else begin
          cmd_o.sq_step = 1'b1;
        end
      end
      StSigStart: begin
        cmd_o.sig_start = 1'b1;
        state_d = StDvSig;
      end
      StDvSig: begin
        if (sts_i.dv_done) begin
          state_d = StSigFix;
        end else begin
          cmd_o.dv_step = 1'b1;
        end
      end
      StSigFix: begin
        cmd_o.sig_fix = 1'b1;
        state_d = StRmInit;
      end
      StRmInit: begin
        cmd_o.rm_init = 1'b1;
        state_d = StRmRd;
      end
      StRmRd: begin
        if (sts_i.src_more) begin
          cmd_o.rd_sel = RdSrc;
          state_d = StRmWr;
        end else begin
          state_d = StRmEnd;
        end
      end
      StRmWr: begin
        cmd_o.rm_wr = 1'b1;
        state_d = StRmRd;
      end
      StRmEnd: begin
        cmd_o.rm_end = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d = sts_i.cnt_zero ? StIdle : StPkInit;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  `SPCF_ASSERT(a_start_taken, (start_i && !busy_o) |=> (state_q == StInsChk))
  `SPCF_ASSERT_NEVER(a_one_write, cmd_o.wr_hit && cmd_o.wr_shift)
  `SPCF_ASSERT(a_emit_next, (state_q == StEmit) |=> (state_q == StIdle || state_q == StPkInit))

endmodule

### design/strip_peak_cluster_finder.sv
// top level of the strip peak cluster finder
// depends on spcf_pkg, spcf_ctrl, spcf_dp (with spcf_ram)
//
//   channel   handshake                      payload
//   hit in    start / busy                   row, strip, adc, time_bin, strip_center, last_hit
//   cluster   cluster_valid_o (one cycle)    row, peak, centre, count, sum, centroid, sigma, last
//   config    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// a kept hit holds busy while each stored hit with a larger key is shifted up one place, then it
// is written (store shift through the one write port); a dropped hit holds it only for the window check
// a hit with last_hit then clusters: a peak search over the stored hits for each cluster,
// a moment step per member and a test per neighbour, the divide and root units,
// and a move of each hit behind the cluster when the cluster is removed
// no clearing pass after reset; the cluster output cannot be stalled
`timescale 1ns / 1ps

module strip_peak_cluster_finder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         row_i,
  input  logic [7:0]         strip_i,
  input  logic [9:0]         adc_i,
  input  logic signed [12:0] time_bin_i,
  input  logic signed [14:0] strip_center_i,
  input  logic               last_hit_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  output logic               cluster_valid_o,
  output logic [2:0]         cluster_row_o,
  output logic [7:0]         peak_strip_o,
  output logic signed [14:0] peak_center_o,
  output logic [6:0]         strip_count_o,
  output logic [15:0]        sum_adc_o,
  output logic signed [14:0] centroid_o,
  output logic [14:0]        sigma_o,
  output logic               last_cluster_o
);

  import spcf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  spcf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  spcf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .row_i           (row_i),
    .strip_i         (strip_i),
    .adc_i           (adc_i),
    .time_bin_i      (time_bin_i),
    .strip_center_i  (strip_center_i),
    .last_hit_i      (last_hit_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cluster_valid_o (cluster_valid_o),
    .cluster_row_o   (cluster_row_o),
    .peak_strip_o    (peak_strip_o),
    .peak_center_o   (peak_center_o),
    .strip_count_o   (strip_count_o),
    .sum_adc_o       (sum_adc_o),
    .centroid_o      (centroid_o),
    .sigma_o         (sigma_o),
    .last_cluster_o  (last_cluster_o)
  );

endmodule

### tb/sv/spcf_checker.sv
// cluster checker for the strip peak cluster finder: watches the hit, config and cluster channels,
// predicts each projection's clusters and compares them field by field
// depends on spcf_pkg
`timescale 1ns / 1ps

module spcf_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         row_i,
  input  logic [7:0]         strip_i,
  input  logic [9:0]         adc_i,
  input  logic signed [12:0] time_bin_i,
  input  logic signed [14:0] strip_center_i,
  input  logic               last_hit_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               cluster_valid_o,
  input  logic [2:0]         cluster_row_o,
  input  logic [7:0]         peak_strip_o,
  input  logic signed [14:0] peak_center_o,
  input  logic [6:0]         strip_count_o,
  input  logic [15:0]        sum_adc_o,
  input  logic signed [14:0] centroid_o,
  input  logic [14:0]        sigma_o,
  input  logic               last_cluster_o,
  output int                 fail_count,
  output int                 pending
);
  import spcf_pkg::*;

  typedef struct packed {
    logic [2:0]         row;
    logic [7:0]         peak;
    logic signed [14:0] peak_center;
    logic [6:0]         count;
    logic [15:0]        sum;
    logic signed [14:0] centroid;
    logic [14:0]        sigma;
    logic               last;
  } cluster_t;

  hit_t               hits [MaxHits];
  int                 n_hits;
  logic signed [12:0] win_lo, win_hi;
  logic [9:0]         thr;
  cluster_t           cluster_q [$];

  assign pending = cluster_q.size();

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit grows(hit_t p, hit_t c);
    if (c.adc > p.adc || c.adc < thr || c.row != p.row) return 0;
    return (c.strip > p.strip ? c.strip - p.strip : p.strip - c.strip) <= 1;
  endfunction

  task automatic store_hit(hit_t h, logic signed [12:0] tb);
    int pos;
    if (tb >= win_lo && tb <= win_hi && n_hits < MaxHits) begin
      pos = n_hits;
      while (pos > 0 && {hits[pos-1].row, hits[pos-1].strip} > {h.row, h.strip}) begin
        hits[pos] = hits[pos-1];
        pos--;
      end
      hits[pos] = h;
      n_hits++;
    end
  endtask

  task automatic find_clusters();
    int peak, left, right, span;
    longint m0, m1, m2, num, rad, cen;
    cluster_t c;
    bit any;
    any = 0;
    while (n_hits > 0) begin
      peak = 0;
      for (int i = 1; i < n_hits; i++) if (hits[i].adc > hits[peak].adc) peak = i;
      left = peak;
      right = peak;
      while (right + 1 < n_hits && grows(hits[right], hits[right+1])) right++;
      while (left > 0 && grows(hits[left], hits[left-1])) left--;
      m0 = 0; m1 = 0; m2 = 0;
      for (int i = left; i <= right; i++) begin
        m0 += hits[i].adc;
        m1 += longint'(hits[i].adc) * hits[i].center;
        m2 += longint'(hits[i].adc) * hits[i].center * hits[i].center;
      end
      cen = hits[peak].center;
      c.sigma = '0;
      if (m0 > 0) begin
        num = 2 * m1 + m0;
        cen = num >= 0 ? num / (2 * m0) : -((-num + 2 * m0 - 1) / (2 * m0));
        rad = m0 * m2 - m1 * m1;
        if (rad < 0) rad = 0;
        c.sigma = 15'(root64(rad) / m0);
      end
      span = right - left + 1;
      c.row = hits[peak].row;
      c.peak = hits[peak].strip;
      c.peak_center = hits[peak].center;
      c.count = 7'(span);
      c.sum = 16'(m0);
      c.centroid = 15'(cen);
      c.last = 0;
      cluster_q = {cluster_q, c};
      any = 1;
      for (int i = left; i + span < n_hits; i++) hits[i] = hits[i+span];
      n_hits -= span;
    end
    if (any) cluster_q[$].last = 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t     h;
    cluster_t exp_c;
    if (!rst_ni) begin
      n_hits = 0;
      win_lo = -13'sd50;
      win_hi = 13'sd50;
      thr = '0;
      fail_count = 0;
      cluster_q.delete();
    end else begin
      if (cluster_valid_o) begin
        if (cluster_q.size() == 0) begin
          $error("cluster with no request pending");
          fail_count++;
        end else begin
          exp_c = cluster_q.pop_front();
          if (cluster_row_o !== exp_c.row) begin
            $error("cluster_row exp %0d got %0d", exp_c.row, cluster_row_o); fail_count++;
          end
          if (peak_strip_o !== exp_c.peak) begin
            $error("peak_strip exp %0d got %0d", exp_c.peak, peak_strip_o); fail_count++;
          end
          if (peak_center_o !== exp_c.peak_center) begin
            $error("peak_center exp %0d got %0d", exp_c.peak_center, peak_center_o);
            fail_count++;
          end
          if (strip_count_o !== exp_c.count) begin
            $error("strip_count exp %0d got %0d", exp_c.count, strip_count_o); fail_count++;
          end
          if (sum_adc_o !== exp_c.sum) begin
            $error("sum_adc exp %0d got %0d", exp_c.sum, sum_adc_o); fail_count++;
          end
          if (centroid_o !== exp_c.centroid) begin
            $error("centroid exp %0d got %0d", exp_c.centroid, centroid_o); fail_count++;
          end
          if (sigma_o !== exp_c.sigma) begin
            $error("sigma exp %0d got %0d", exp_c.sigma, sigma_o); fail_count++;
          end
          if (last_cluster_o !== exp_c.last) begin
            $error("last_cluster exp %0d got %0d", exp_c.last, last_cluster_o); fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgWinLo: win_lo = cfg_data_i;
          CfgWinHi: win_hi = cfg_data_i;
          CfgThr:   thr = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        h.row = row_i;
        h.strip = strip_i;
        h.adc = adc_i;
        h.center = strip_center_i;
        store_hit(h, time_bin_i);
        if (last_hit_i) find_clusters();
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
// testbench top for strip_peak_cluster_finder: drives directed and random projections
// and config settings; depends on spcf_pkg, spcf_checker and the block
`timescale 1ns / 1ps

module tb_top;
  import spcf_pkg::*;

  localparam logic [1:0] CfgNone = 2'd3;
  localparam int Limit = 3000000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start = 0;
  logic               busy;
  logic [2:0]         row_i = '0;
  logic [7:0]         strip_i = '0;
  logic [9:0]         adc_i = '0;
  logic signed [12:0] time_bin_i = '0;
  logic signed [14:0] strip_center_i = '0;
  logic               last_hit_i = 0;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [12:0]        cfg_data_i = '0;
  logic               cluster_valid_o;
  logic [2:0]         cluster_row_o;
  logic [7:0]         peak_strip_o;
  logic signed [14:0] peak_center_o;
  logic [6:0]         strip_count_o;
  logic [15:0]        sum_adc_o;
  logic signed [14:0] centroid_o;
  logic [14:0]        sigma_o;
  logic               last_cluster_o;
  int                 fail_count, pending;

  int                 cycles = 0;
  int                 sent = 0;
  bit                 gaps_on = 1;
  int                 win_lo = -50, win_hi = 50;

  always #4 clk_i = ~clk_i;

  strip_peak_cluster_finder dut (.*);
  spcf_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_hit(int row, int strip, int adc, int tb, int center, bit last);
    if (gaps_on && $urandom_range(99) < 30) begin
      start = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start = 1;
    row_i = 3'(row);
    strip_i = 8'(strip);
    adc_i = 10'(adc);
    time_bin_i = 13'(tb);
    strip_center_i = 15'(center);
    last_hit_i = last;
    forever begin
      if (!busy) begin
        @(posedge clk_i);
        break;
      end
      @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int data);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = 13'(data);
    forever begin
      if (cfg_ready_o) begin
        @(posedge clk_i);
        break;
      end
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic set_window(int lo, int hi, int thr);
    write_reg(CfgWinLo, lo);
    write_reg(CfgWinHi, hi);
    write_reg(CfgThr, thr);
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic projection(int n);
    int row, strip, adc, tb, center;
    row = $urandom_range(7);
    strip = $urandom_range(255);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) row = $urandom_range(7);
      if ($urandom_range(99) < 20) strip = $urandom_range(255);
      else strip = (strip + $urandom_range(0, 3) + 255) % 256;
      case ($urandom_range(9))
        0: adc = 0;
        1: adc = 1023;
        default: adc = $urandom_range(1023);
      endcase
      if ($urandom_range(99) < 85 && win_lo <= win_hi) begin
        tb = $urandom_range(win_hi - win_lo) + win_lo;
      end else begin
        tb = int'($urandom_range(8191)) - 4096;
      end
      if ($urandom_range(99) < 20) center = int'($urandom_range(32767)) - 16384;
      else center = strip * 16 + row * 4096 - 16384;
      send_hit(row, strip, adc, tb, center, i == n - 1);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // single hits at the field extremes, zero adc, rejected last hit, empty projection
    send_hit(7, 255, 1023, 50, 16383, 1);
    send_hit(0, 0, 0, -50, -16384, 1);
    send_hit(3, 10, 500, 0, 100, 0);
    send_hit(3, 11, 400, 51, 120, 1);
    send_hit(1, 1, 1, -51, 5, 1);
    // equal keys, a peak with falling neighbours in one row and a lone hit in the next row, zero-adc cluster
    send_hit(2, 40, 300, 1, 640, 0);
    send_hit(2, 40, 300, 2, 641, 0);
    send_hit(2, 41, 900, 3, 656, 0);
    send_hit(2, 42, 600, 4, 672, 0);
    send_hit(2, 43, 700, 5, 688, 0);
    send_hit(3, 0, 200, 6, 4096, 0);
    send_hit(5, 7, 0, 7, 112, 0);
    send_hit(5, 8, 0, 8, 128, 1);
    drain();

    set_window(-4096, 4095, 1023);
    send_hit(4, 100, 800, -4096, -1000, 0);
    send_hit(4, 101, 800, 4095, 1000, 0);
    send_hit(4, 99, 1023, 0, 0, 1);
    drain();
    for (int p = 0; p < 3; p++) projection($urandom_range(2, 10));
    drain();

    // inverted window, then unknown register and a wide window
    set_window(20, -20, 0);
    projection(4);
    drain();
    write_reg(CfgNone, 13'h1fff);
    set_window(-4096, 4095, 0);
    projection(70);
    drain();

    gaps_on = 0;
    set_window(-300, 300, 100);
    while (sent < 130) projection($urandom_range(1, 8));
    drain();

    gaps_on = 1;
    set_window(-50, 50, $urandom_range(1, 1022));
    while (sent < 175) projection($urandom_range(1, 12));
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
